FILE: hdl/dbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dbs_pkg
// Shared types and constants of the depth bucket sorter.
// -----------------------------------------------------------------------------
package dbs_pkg;

   localparam int DEPTH_W    = 32;
   localparam int KIND_W     = 3;
   localparam int PAYLOAD_W  = 32;
   localparam int STATUS_W   = 3;
   localparam int FREE_W     = 7;
   localparam int DMAX_W     = 31;
   localparam int SCALE_W    = 33;
   localparam int PROD_W     = DMAX_W + SCALE_W;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 33;

   typedef enum logic [STATUS_W-1:0] {
      ST_STORED   = 3'd0,
      ST_RANGE    = 3'd1,
      ST_FULL     = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_DRAINED  = 3'd4
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEPTH_MAX   = 1'd0,
      CSR_DEPTH_SCALE = 1'd1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: hdl/dbs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dbs_req_if / dbs_rsp_if
// Valid/ready channels carrying request and response words.
// -----------------------------------------------------------------------------
interface dbs_req_if;
   logic                          valid;
   logic                          ready;
   logic                          mode;
   logic [dbs_pkg::DEPTH_W-1:0]   depth;
   logic [dbs_pkg::KIND_W-1:0]    kind;
   logic [dbs_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, mode, depth, kind, payload, input ready);
   modport sink   (input valid, mode, depth, kind, payload, output ready);
endinterface

interface dbs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dbs_pkg::STATUS_W-1:0]  status;
   logic [dbs_pkg::FREE_W-1:0]    free_left;
   logic                          valid_res;
   logic [dbs_pkg::PAYLOAD_W-1:0] item_payload;
   logic [dbs_pkg::KIND_W-1:0]    item_kind;
   logic [dbs_pkg::DEPTH_W-1:0]   item_depth;
   logic                          last;

   modport source (output valid, status, free_left, valid_res, item_payload, item_kind,
                   item_depth, last, input ready);
   modport sink   (input valid, status, free_left, valid_res, item_payload, item_kind,
                   item_depth, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/dbs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dbs_ram
// Generic single write port, single read port RAM with registered read data.
// -----------------------------------------------------------------------------
module dbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dbs_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// dbs_mul
// Two-pass multiplier: one 16 x 33 bit unit forms the low and high halves of
// depth times scale and accumulates them.
// -----------------------------------------------------------------------------
module dbs_mul (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [dbs_pkg::DMAX_W-1:0]   op_a,
   input  wire logic [dbs_pkg::SCALE_W-1:0]  op_b,
   output logic                              done,
   output logic      [dbs_pkg::PROD_W-1:0]   prod
);

   typedef enum logic {M_IDLE, M_HIGH} mstate_type;

   mstate_type                         state_ff;
   logic                               done_ff;
   logic [dbs_pkg::PROD_W-1:0]         acc_ff;
   logic [15:0]                        part;
   logic [15+dbs_pkg::SCALE_W:0]       partial;

   always_comb begin
      part    = (state_ff == M_HIGH) ? {1'b0, op_a[30:16]} : op_a[15:0];
      partial = part * op_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (start) begin
                  acc_ff   <= {15'd0, partial};
                  state_ff <= M_HIGH;
               end
            end
            M_HIGH: begin
               acc_ff   <= acc_ff + {partial[47:0], 16'd0};
               done_ff  <= 1'b1;
               state_ff <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

`default_nettype wire

FILE: hdl/depth_bucket_sorter.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// depth_bucket_sorter
// Depth sorter that keeps items in ordered linked lists, one per depth bucket.
// -----------------------------------------------------------------------------
// After reset the block sweeps the bucket head memory, clearing every entry, before
// it accepts a word. An insert walks the list of its bucket, reading and then
// comparing one entry at a time until it finds its place; one 16 x 33
// multiplier forms the bucket index in two passes. A drain scans the head
// memory from the top bucket down and reads out every entry of each list.
module depth_bucket_sorter #(
   parameter int BUCKETS   = 64,
   parameter int POOL_SIZE = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   dbs_req_if.sink                                req_ch,
   dbs_rsp_if.source                              rsp_ch,
   input  wire logic                              csr_we,
   input  wire logic [dbs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [dbs_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int PW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
   localparam int BW = $clog2(BUCKETS);
   localparam int HW = PW + 1;
   localparam int EW = PW + 1 + dbs_pkg::DEPTH_W + dbs_pkg::KIND_W + dbs_pkg::PAYLOAD_W;
   localparam int FW = dbs_pkg::FREE_W;
   localparam logic [FW-1:0] POOL_FULL = FW'(POOL_SIZE);
   localparam logic [BW-1:0] TOP_BUCKET = BW'(BUCKETS - 1);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_MUL, S_HRD, S_HCHK, S_ERD, S_ECMP, S_WSLOT, S_WLINK,
      S_RESP, D_HRD, D_HCHK, D_ERD, D_EOUT
   } state_type;

   state_type                          state_ff;
   logic [dbs_pkg::DMAX_W-1:0]         depth_max_ff;
   logic [dbs_pkg::SCALE_W-1:0]        depth_scale_ff;
   logic [dbs_pkg::DEPTH_W-1:0]        depth_ff;
   logic [dbs_pkg::KIND_W-1:0]         kind_ff;
   logic [dbs_pkg::PAYLOAD_W-1:0]      payload_ff;
   logic [BW-1:0]                      bucket_ff;
   logic [PW-1:0]                      slot_ff;
   logic [PW-1:0]                      cur_ff;
   logic                               cur_v_ff;
   logic [PW-1:0]                      prev_ff;
   logic                               prev_v_ff;
   logic [EW-1:0]                      prev_word_ff;
   logic [FW-1:0]                      free_ff;
   logic [FW-1:0]                      cnt_ff;
   dbs_pkg::status_type                res_status_ff;
   logic [FW-1:0]                      res_free_ff;

   logic                               rsp_valid_ff;
   dbs_pkg::status_type                rsp_status_ff;
   logic [FW-1:0]                      rsp_free_ff;
   logic                               rsp_vres_ff;
   logic [dbs_pkg::PAYLOAD_W-1:0]      rsp_payload_ff;
   logic [dbs_pkg::KIND_W-1:0]         rsp_kind_ff;
   logic [dbs_pkg::DEPTH_W-1:0]        rsp_depth_ff;
   logic                               rsp_last_ff;

   logic                               head_we, head_re;
   logic [BW-1:0]                      head_waddr;
   logic [HW-1:0]                      head_wdata, head_rdata;
   logic                               ent_we, ent_re;
   logic [PW-1:0]                      ent_waddr, ent_raddr;
   logic [EW-1:0]                      ent_wdata, ent_rdata;

   logic                               mul_start, mul_done;
   logic [dbs_pkg::DMAX_W-1:0]         mul_a;
   logic [dbs_pkg::PROD_W-1:0]         mul_prod;

   logic                               out_free, accept, load_rsp, ins_ok;
   logic                               e_link_v;
   logic [PW-1:0]                      e_link;
   logic [dbs_pkg::DEPTH_W-1:0]        e_depth;
   logic [dbs_pkg::KIND_W-1:0]         e_kind;
   logic [dbs_pkg::PAYLOAD_W-1:0]      e_payload;
   logic                               goes_before;
   logic [FW-1:0]                      stored;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign accept   = req_ch.valid && (state_ff == S_IDLE);
   assign load_rsp = out_free && ((state_ff == S_RESP) || (state_ff == D_EOUT));
   assign stored   = POOL_FULL - free_ff;
   assign ins_ok   = !req_ch.depth[31] && (req_ch.depth[30:0] <= depth_max_ff) &&
                     (free_ff != '0);
   assign mul_a    = (state_ff == S_IDLE) ? req_ch.depth[30:0] : depth_ff[30:0];

   assign {e_link_v, e_link, e_depth, e_kind, e_payload} = ent_rdata;
   assign goes_before = ($signed(e_depth) < $signed(depth_ff)) ||
                        ((e_depth == depth_ff) && (e_kind < kind_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_max_ff   <= {dbs_pkg::DMAX_W{1'b1}};
         depth_scale_ff <= '0;
      end else if (csr_we) begin
         case (dbs_pkg::csr_index_type'(csr_index))
            dbs_pkg::CSR_DEPTH_MAX:   depth_max_ff   <= csr_wdata[dbs_pkg::DMAX_W-1:0];
            dbs_pkg::CSR_DEPTH_SCALE: depth_scale_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      head_we    = 1'b0;
      head_re    = 1'b0;
      head_waddr = bucket_ff;
      head_wdata = '0;
      ent_we     = 1'b0;
      ent_re     = 1'b0;
      ent_waddr  = slot_ff;
      ent_raddr  = cur_ff;
      ent_wdata  = {cur_v_ff, cur_ff, depth_ff, kind_ff, payload_ff};
      mul_start  = 1'b0;
      case (state_ff)
         S_CLR:   head_we = 1'b1;
         S_IDLE:  mul_start = accept && !req_ch.mode && ins_ok;
         S_HRD:   head_re = 1'b1;
         S_ERD:   ent_re = 1'b1;
         D_HRD:   head_re = 1'b1;
         D_ERD:   ent_re = 1'b1;
         D_HCHK:  head_we = 1'b1;
         S_WSLOT: ent_we = 1'b1;
         S_WLINK: begin
            if (prev_v_ff) begin
               ent_we    = 1'b1;
               ent_waddr = prev_ff;
               ent_wdata = {1'b1, slot_ff, prev_word_ff[EW-HW-1:0]};
            end else begin
               head_we    = 1'b1;
               head_wdata = {1'b1, slot_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         bucket_ff    <= TOP_BUCKET;
         free_ff      <= POOL_FULL;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ch.ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLR: begin
               if (bucket_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  bucket_ff <= bucket_ff - 1'b1;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  depth_ff   <= req_ch.depth;
                  kind_ff    <= req_ch.kind;
                  payload_ff <= req_ch.payload;
                  if (req_ch.mode) begin
                     res_status_ff <= dbs_pkg::ST_DRAINED;
                     res_free_ff   <= POOL_FULL;
                     cnt_ff        <= '0;
                     bucket_ff     <= TOP_BUCKET;
                     state_ff      <= (free_ff == POOL_FULL) ? S_RESP : D_HRD;
                  end else if (req_ch.depth[31] ||
                               (req_ch.depth[30:0] > depth_max_ff)) begin
                     res_status_ff <= dbs_pkg::ST_RANGE;
                     res_free_ff   <= free_ff;
                     state_ff      <= S_RESP;
                  end else if (free_ff == '0) begin
                     res_status_ff <= dbs_pkg::ST_FULL;
                     res_free_ff   <= '0;
                     state_ff      <= S_RESP;
                  end else begin
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               if (mul_done) begin
                  if (mul_prod[63:32] >= 32'(BUCKETS)) begin
                     res_status_ff <= dbs_pkg::ST_OVERFLOW;
                     res_free_ff   <= free_ff;
                     state_ff      <= S_RESP;
                  end else begin
                     bucket_ff <= mul_prod[32+BW-1:32];
                     free_ff   <= free_ff - 1'b1;
                     slot_ff   <= PW'(free_ff - 1'b1);
                     state_ff  <= S_HRD;
                  end
               end
            end
            S_HRD: state_ff <= S_HCHK;
            S_HCHK: begin
               cur_v_ff  <= head_rdata[PW];
               cur_ff    <= head_rdata[PW-1:0];
               prev_v_ff <= 1'b0;
               state_ff  <= head_rdata[PW] ? S_ERD : S_WSLOT;
            end
            S_ERD: state_ff <= S_ECMP;
            S_ECMP: begin
               if (goes_before) begin
                  prev_ff      <= cur_ff;
                  prev_v_ff    <= 1'b1;
                  prev_word_ff <= ent_rdata;
                  cur_v_ff     <= e_link_v;
                  cur_ff       <= e_link;
                  state_ff     <= e_link_v ? S_ERD : S_WSLOT;
               end else begin
                  state_ff <= S_WSLOT;
               end
            end
            S_WSLOT: state_ff <= S_WLINK;
            S_WLINK: begin
               res_status_ff <= dbs_pkg::ST_STORED;
               res_free_ff   <= free_ff;
               state_ff      <= S_RESP;
            end
            S_RESP: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= res_status_ff;
                  rsp_free_ff    <= res_free_ff;
                  rsp_vres_ff    <= 1'b0;
                  rsp_payload_ff <= '0;
                  rsp_kind_ff    <= '0;
                  rsp_depth_ff   <= '0;
                  rsp_last_ff    <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            D_HRD: state_ff <= D_HCHK;
            D_HCHK: begin
               if (head_rdata[PW]) begin
                  cur_ff   <= head_rdata[PW-1:0];
                  state_ff <= D_ERD;
               end else if (bucket_ff == '0) begin
                  free_ff  <= POOL_FULL;
                  state_ff <= S_IDLE;
               end else begin
                  bucket_ff <= bucket_ff - 1'b1;
                  state_ff  <= D_HRD;
               end
            end
            D_ERD: state_ff <= D_EOUT;
            D_EOUT: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_status_ff  <= dbs_pkg::ST_DRAINED;
                  rsp_free_ff    <= POOL_FULL;
                  rsp_vres_ff    <= 1'b1;
                  rsp_payload_ff <= e_payload;
                  rsp_kind_ff    <= e_kind;
                  rsp_depth_ff   <= e_depth;
                  rsp_last_ff    <= (cnt_ff + 1'b1 == stored);
                  cnt_ff         <= cnt_ff + 1'b1;
                  if (e_link_v) begin
                     cur_ff   <= e_link;
                     state_ff <= D_ERD;
                  end else if (bucket_ff == '0) begin
                     free_ff  <= POOL_FULL;
                     state_ff <= S_IDLE;
                  end else begin
                     bucket_ff <= bucket_ff - 1'b1;
                     state_ff  <= D_HRD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   dbs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (depth_scale_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   dbs_ram #(.WIDTH(HW), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (head_re),
      .rd_addr (bucket_ff),
      .rd_data (head_rdata)
   );

   dbs_ram #(.WIDTH(EW), .DEPTH(POOL_SIZE)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.free_left    = rsp_free_ff;
   assign rsp_ch.valid_res    = rsp_vres_ff;
   assign rsp_ch.item_payload = rsp_payload_ff;
   assign rsp_ch.item_kind    = rsp_kind_ff;
   assign rsp_ch.item_depth   = rsp_depth_ff;
   assign rsp_ch.last         = rsp_last_ff;

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= POOL_FULL) else $error("free count exceeds pool size");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ch.ready) else $error("accepted a word while busy");

   a_drain_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == D_EOUT) |-> (cnt_ff < stored)) else $error("drain emits too many words");

   a_mul_done: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_MUL)) else $error("multiplier finished out of turn");

endmodule

`default_nettype wire

FILE: tb/depth_bucket_sorter_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// depth_bucket_sorter_test
// Drives insert and drain words into the depth bucket sorter under random
// idling and back pressure, predicts every response word from an ordered
// per-bucket model, and compares each response field by field.
// -----------------------------------------------------------------------------
module depth_bucket_sorter_test;

   localparam int BUCKETS   = 64;
   localparam int POOL_SIZE = 64;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      dbs_pkg::status_type                status;
      logic [dbs_pkg::FREE_W-1:0]         free_left;
      logic                               valid_res;
      logic [31:0]                        item_payload;
      logic [2:0]                         item_kind;
      logic [31:0]                        item_depth;
      logic                               last;
   } sorted_word_type;

   typedef struct {
      logic signed [31:0] depth;
      logic [2:0]         kind;
      logic [31:0]        payload;
   } stored_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [dbs_pkg::CSR_IDX_W-1:0] csr_index = dbs_pkg::CSR_DEPTH_MAX;
   logic [dbs_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   dbs_req_if req_ch();
   dbs_rsp_if rsp_ch();

   depth_bucket_sorter #(.BUCKETS(BUCKETS), .POOL_SIZE(POOL_SIZE)) u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   logic [dbs_pkg::DMAX_W-1:0]  pred_depth_max = 31'h7FFF_FFFF;
   logic [dbs_pkg::SCALE_W-1:0] pred_scale = '0;
   stored_item_type    bucket_list[BUCKETS][$];
   int                 free_entries = POOL_SIZE;
   sorted_word_type    expected_words[$];
   int                 mismatches = 0;
   bit                 idle_on = 1'b1;
   int                 rsp_hold = 0;
   int                 quiet_cycles = 0;

   initial begin
      req_ch.valid <= 1'b0;
      req_ch.mode <= 1'b0;
      req_ch.depth <= '0;
      req_ch.kind <= '0;
      req_ch.payload <= '0;
      rsp_ch.ready <= 1'b0;
   end

   function automatic sorted_word_type make_word(dbs_pkg::status_type st, int fl);
      sorted_word_type w;
      w = '0;
      w.status = st;
      w.free_left = fl[dbs_pkg::FREE_W-1:0];
      w.last = 1'b1;
      return w;
   endfunction

   function automatic void predict_word(logic mode, logic [31:0] depth, logic [2:0] kind,
                                        logic [31:0] payload);
      logic signed [31:0] sd;
      logic [63:0] prod;
      stored_item_type it;
      sorted_word_type w;
      int b;
      int i;
      int n;
      sd = depth;
      n = 0;
      if (mode) begin
         for (b = BUCKETS - 1; b >= 0; b--) begin
            foreach (bucket_list[b][j]) begin
               w = make_word(dbs_pkg::ST_DRAINED, POOL_SIZE);
               w.valid_res = 1'b1;
               w.item_payload = bucket_list[b][j].payload;
               w.item_kind = bucket_list[b][j].kind;
               w.item_depth = bucket_list[b][j].depth;
               w.last = 1'b0;
               expected_words.push_back(w);
               n++;
            end
            bucket_list[b].delete();
         end
         free_entries = POOL_SIZE;
         if (n == 0)
            expected_words.push_back(make_word(dbs_pkg::ST_DRAINED, POOL_SIZE));
         else
            expected_words[expected_words.size() - 1].last = 1'b1;
      end else if (sd < 0 || sd > $signed({1'b0, pred_depth_max})) begin
         expected_words.push_back(make_word(dbs_pkg::ST_RANGE, free_entries));
      end else if (free_entries == 0) begin
         expected_words.push_back(make_word(dbs_pkg::ST_FULL, 0));
      end else begin
         prod = {32'd0, depth} * {31'd0, pred_scale};
         if (prod[63:32] >= BUCKETS) begin
            expected_words.push_back(make_word(dbs_pkg::ST_OVERFLOW, free_entries));
         end else begin
            b = prod[63:32];
            free_entries--;
            i = 0;
            while (i < bucket_list[b].size() && (bucket_list[b][i].depth < sd ||
                   (bucket_list[b][i].depth == sd && bucket_list[b][i].kind < kind)))
               i++;
            it.depth = sd;
            it.kind = kind;
            it.payload = payload;
            bucket_list[b].insert(i, it);
            expected_words.push_back(make_word(dbs_pkg::ST_STORED, free_entries));
         end
      end
   endfunction

   initial begin
      sorted_word_type actual;
      sorted_word_type want;
      int gap;
      gap = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            actual.status = dbs_pkg::status_type'(rsp_ch.status);
            actual.free_left = rsp_ch.free_left;
            actual.valid_res = rsp_ch.valid_res;
            actual.item_payload = rsp_ch.item_payload;
            actual.item_kind = rsp_ch.item_kind;
            actual.item_depth = rsp_ch.item_depth;
            actual.last = rsp_ch.last;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: status %0d free %0d payload %h", actual.status,
                           actual.free_left, actual.item_payload);
            end else begin
               want = expected_words.pop_front();
               if (actual !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected st %0d fl %0d v %0d pay %h k %0d d %h l %0d,",
                               " got st %0d fl %0d v %0d pay %h k %0d d %h l %0d"},
                              want.status, want.free_left, want.valid_res, want.item_payload,
                              want.item_kind, want.item_depth, want.last, actual.status,
                              actual.free_left, actual.valid_res, actual.item_payload,
                              actual.item_kind, actual.item_depth, actual.last);
               end
            end
            gap = idle_on ? $urandom_range(0, 8) : 0;
         end else if (gap > 0) begin
            gap--;
         end
         if (rsp_hold > 0)
            rsp_hold--;
         rsp_ch.ready <= !reset && gap == 0 && rsp_hold == 0;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("depth_bucket_sorter_test: FAIL");
            $finish;
         end
      end
   end

   task automatic send_word(logic mode, logic [31:0] depth, logic [2:0] kind,
                            logic [31:0] payload);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.mode <= mode;
      req_ch.depth <= depth;
      req_ch.kind <= kind;
      req_ch.payload <= payload;
      do @(posedge clock); while (!req_ch.ready);
      predict_word(mode, depth, kind, payload);
   endtask

   task automatic insert_word(logic [31:0] depth, logic [2:0] kind);
      send_word(1'b0, depth, kind, $urandom);
   endtask

   task automatic drain_all();
      send_word(1'b1, $urandom, 3'($urandom), $urandom);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_config(logic [dbs_pkg::DMAX_W-1:0] dmax,
                             logic [dbs_pkg::SCALE_W-1:0] scale);
      wait_drained();
      csr_we <= 1'b1;
      csr_index <= dbs_pkg::CSR_DEPTH_MAX;
      csr_wdata <= {2'b00, dmax};
      @(posedge clock);
      csr_index <= dbs_pkg::CSR_DEPTH_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_we <= 1'b0;
      pred_depth_max = dmax;
      pred_scale = scale;
   endtask

   task automatic test_directed();
      drain_all();
      insert_word(32'h8000_0000, 3'd0);
      insert_word(32'hFFFF_FFFF, 3'd7);
      insert_word(32'd0, 3'd7);
      insert_word(32'd0, 3'd0);
      insert_word(32'd0, 3'd0);
      insert_word(32'h7FFF_FFFF, 3'd3);
      drain_all();
      set_config(31'h0010_0000, 33'h0_0004_0000);
      insert_word(32'h0010_0001, 3'd1);
      insert_word(32'h0010_0000, 3'd1);
      insert_word(32'h000F_FFFF, 3'd2);
      insert_word(32'h0000_4000, 3'd5);
      insert_word(32'h0000_4000, 3'd2);
      insert_word(32'h0000_4000, 3'd5);
      drain_all();
      set_config(31'd0, 33'h1_0000_0000);
      insert_word(32'd0, 3'd4);
      insert_word(32'd1, 3'd4);
      set_config(31'h7FFF_FFFF, 33'h1_0000_0000);
      insert_word(32'd63, 3'd6);
      insert_word(32'd64, 3'd6);
      insert_word(32'h7FFF_FFFF, 3'd6);
      drain_all();
   endtask

   task automatic test_pool_full();
      set_config(31'h7FFF_FFFF, 33'h0_0000_0080);
      repeat (POOL_SIZE + 2) insert_word($urandom_range(0, 32'h7FFF_FFFF), 3'($urandom));
      drain_all();
   endtask

   task automatic test_backpressure();
      wait_drained();
      rsp_hold = 400;
      repeat (30) insert_word($urandom_range(0, 32'h7FFF_FFFF), 3'($urandom));
      wait_drained();
      drain_all();
   endtask

   task automatic test_random(int items);
      logic [31:0] d;
      logic [31:0] base;
      int pick;
      base = $urandom_range(0, pred_depth_max);
      repeat (items) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            drain_all();
         end else begin
            if (pick < 15)
               d = $urandom;
            else if (pick < 45)
               d = base + $urandom_range(0, 3);
            else
               d = $urandom_range(0, pred_depth_max);
            insert_word(d, 3'($urandom));
         end
      end
      drain_all();
   endtask

   task automatic test_random_settings();
      int phase;
      for (phase = 0; phase < 6; phase++) begin
         idle_on = phase != 2;
         case ($urandom_range(0, 3))
            0: set_config(31'h7FFF_FFFF, 33'h0_0000_0080);
            1: set_config(31'h0010_0000, 33'h0_0004_0000);
            2: set_config(31'h0000_0FFF, 33'h1_0000_0000);
            default: begin
               set_config(31'($urandom), {1'b0, $urandom} >> $urandom_range(20, 31));
            end
         endcase
         test_random(25);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_pool_full();
      test_backpressure();
      test_random_settings();
      wait_drained();
      if (mismatches == 0)
         $display("depth_bucket_sorter_test: PASS");
      else
         $display("depth_bucket_sorter_test: FAIL");
      $finish;
   end

endmodule
